>>> rtl/wtosc_pkg.sv
// Shared constants, register codes and helper functions of the wavetable oscillator.
package wtosc_pkg;

	localparam int TABLE_SIZE = 1024;
	localparam int NUM_WAVES  = 4;

	localparam int IDX_W     = $clog2(TABLE_SIZE);
	localparam int MEM_DEPTH = NUM_WAVES * TABLE_SIZE;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam int SEL_W     = 2;
	localparam int WAVE_W    = 2;
	localparam int TADDR_W   = 10;
	localparam int SAMP_W    = 16;
	localparam int FREQ_W    = 23;
	localparam int PHASE_W   = 32;
	localparam int HZ_W      = 37;
	localparam int FACT_W    = 16;
	localparam int CFG_W     = 37;
	localparam int CFG_IDX_W = 2;

	// Shared multiplier operand and product widths.
	localparam int MA_W = 38;
	localparam int MB_W = 18;
	localparam int MP_W = MA_W + MB_W;
	// Width of a product after the rounding shift by 32.
	localparam int SAT_IN_W = MP_W - 32;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_WRITE  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE      = 2'd0,
		REG_WAVE_SELECT = 2'd1,
		REG_HZ_TO_PHASE = 2'd2,
		REG_FREQ_LIMIT  = 2'd3
	} cfg_reg_t;

	localparam logic             ENABLE_RST      = 1'b1;
	localparam logic [SEL_W-1:0] WAVE_SELECT_RST = '0;
	localparam logic [HZ_W-1:0]  HZ_TO_PHASE_RST = 37'd5864062015;
	localparam logic [FREQ_W-1:0] FREQ_LIMIT_RST = 23'd6144000;

	// First entry of the selected table; an out-of-range select wraps around.
	function automatic logic [ADDR_W-1:0] table_base(input logic [SEL_W-1:0] sel);
		return ADDR_W'((int'(sel) % NUM_WAVES) * TABLE_SIZE);
	endfunction

	// Clamp a wide signed value to the 16-bit sample range.
	function automatic logic signed [SAMP_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] x);
		if (x[SAT_IN_W-1:SAMP_W-1] == {(SAT_IN_W-SAMP_W+1){x[SAT_IN_W-1]}})
			return x[SAMP_W-1:0];
		else if (x[SAT_IN_W-1])
			return {1'b1, {(SAMP_W-1){1'b0}}};
		else
			return {1'b0, {(SAMP_W-1){1'b1}}};
	endfunction

endpackage

>>> rtl/wavetable_oscillator_stereo_pan.sv
// Wavetable oscillator with linear interpolation and stereo pan, top level.
//
// Usage. Words enter on the input channel (in_valid / in_ready). A word with
// cmd = write stores table_data into entry table_addr of table table_wave at
// acceptance; writes outside the tables are dropped. A word with cmd = sample reads
// the selected table at the current phase plus phase_offset, interpolates
// between two neighboring entries, scales by amplitude and gain, pans the
// result into left and right, and then advances the phase by the clamped
// frequency times hz_to_phase. When enable is low a sample word gives no
// output word but the phase still advances.
// Timing. All arithmetic runs through one shared 38 x 18 bit multiplier under a
// small sequencer, and the two table entries come from one memory read port one
// after the other. A sample word occupies the block until its phase update is
// done, and a disabled one skips the signal path; a table write leaves the
// block idle. The output word is loaded before the phase advances.
// Stalls. The finished word waits in an output register while the next input
// word is accepted; a second result that finds the register still full holds
// the sequencer until the receiver takes the first one.
// Reset. The phase clears to zero and the control, output and configuration
// registers take their reset values. The table memory is not cleared: entries
// read before being written are undefined. The user must write configuration through
// cfg_we / cfg_addr / cfg_wdata while the block is idle; the block does not enforce it.
module wavetable_oscillator_stereo_pan (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            cmd,
	input  logic [wtosc_pkg::WAVE_W-1:0]    table_wave,
	input  logic [wtosc_pkg::TADDR_W-1:0]   table_addr,
	input  logic signed [wtosc_pkg::SAMP_W-1:0] table_data,
	input  logic [wtosc_pkg::FREQ_W-1:0]    freq_word,
	input  logic [wtosc_pkg::PHASE_W-1:0]   phase_offset,
	input  logic [wtosc_pkg::FACT_W-1:0]    amplitude,
	input  logic [wtosc_pkg::FACT_W-1:0]    gain,
	input  logic signed [wtosc_pkg::SAMP_W-1:0] pan,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [wtosc_pkg::SAMP_W-1:0] left,
	output logic signed [wtosc_pkg::SAMP_W-1:0] right,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [wtosc_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [wtosc_pkg::CFG_W-1:0]     cfg_wdata
);
	import wtosc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_IDX_MUL,
		S_RDA,
		S_RDB,
		S_DIFF,
		S_V,
		S_AMP,
		S_GAIN,
		S_LEFT,
		S_RIGHT,
		S_RSAT,
		S_INC_LO,
		S_INC_HI,
		S_ADV
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic               enable_q;
	logic [SEL_W-1:0]   wave_select_q;
	logic [HZ_W-1:0]    hz_to_phase_q;
	logic [FREQ_W-1:0]  freq_limit_q;

	logic [PHASE_W-1:0] phase_q;

	// Datapath registers for the word in flight.
	logic [PHASE_W-1:0]         p_q;
	logic [FREQ_W-1:0]          fc_q;
	logic [FACT_W-1:0]          amp_q;
	logic [FACT_W-1:0]          gain_q;
	logic signed [SAMP_W-1:0]   pan_q;
	logic [IDX_W-1:0]           idx_q;
	logic [15:0]                f_q;
	logic signed [SAMP_W-1:0]   a_q;
	logic signed [SAMP_W-1:0]   rd_q;
	logic signed [MA_W-1:0]     acc_q;
	logic signed [MP_W-1:0]     prod_q;
	logic [MP_W-1:0]            lo_q;
	logic signed [SAMP_W-1:0]   lpend_q;

	logic signed [SAMP_W-1:0]   left_q;
	logic signed [SAMP_W-1:0]   right_q;
	logic                       out_valid_q;

	// Table memory.
	logic signed [SAMP_W-1:0]   mem [MEM_DEPTH];

	logic                       in_fire;
	logic                       wr_en;
	logic [ADDR_W-1:0]          wr_addr;
	logic [ADDR_W-1:0]          rd_addr;
	logic [ADDR_W-1:0]          base;
	logic [IDX_W-1:0]           idx_raw;
	logic [IDX_W-1:0]           idx_c;
	logic signed [SAMP_W:0]     diff;
	logic [SAMP_W-1:0]          wl;
	logic [SAMP_W:0]            wr;
	logic signed [MA_W-1:0]     mul_a;
	logic signed [MB_W-1:0]     mul_b;
	logic signed [MP_W-1:0]     prod;
	logic signed [MP_W-1:0]     rounded;
	logic [MP_W+16:0]           inc_sum;
	logic                       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign left      = left_q;
	assign right     = right_q;
	assign out_free  = !out_valid_q || out_ready;

	// Table writes land directly at acceptance; anything outside the tables is dropped.
	assign wr_en   = in_fire && (cmd == CMD_WRITE) && (int'(table_wave) < NUM_WAVES)
	                 && (int'(table_addr) < TABLE_SIZE);
	assign wr_addr = ADDR_W'(int'(table_wave) * TABLE_SIZE + int'(table_addr));

	// The scaled phase sits in prod_q after S_IDX_MUL: integer part from bit 32 up,
	// interpolation fraction in bits 31..16. The last entry pairs with the one before.
	assign base    = table_base(wave_select_q);
	assign idx_raw = prod_q[32+IDX_W-1:32];
	assign idx_c   = (idx_raw > IDX_W'(TABLE_SIZE - 2)) ? IDX_W'(TABLE_SIZE - 2) : idx_raw;
	assign rd_addr = (state_q == S_RDB) ? (base + ADDR_W'(idx_q) + ADDR_W'(1))
	                                    : (base + ADDR_W'(idx_c));

	assign diff = {rd_q[SAMP_W-1], rd_q} - {a_q[SAMP_W-1], a_q};
	// Pan weights in Q0.16 (the right one in Q1.16): left gets pan + 0.5 scaled, right the rest of one.
	assign wl   = {~pan_q[SAMP_W-1], pan_q[SAMP_W-2:0]};
	assign wr   = (SAMP_W+1)'(1 << SAMP_W) - {1'b0, wl};

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_IDX_MUL: begin
				mul_a = signed'({{(MA_W-PHASE_W){1'b0}}, p_q});
				mul_b = MB_W'(TABLE_SIZE - 1);
			end
			S_DIFF: begin
				mul_a = MA_W'(diff);
				mul_b = signed'({{(MB_W-16){1'b0}}, f_q});
			end
			S_AMP: begin
				mul_a = acc_q;
				mul_b = signed'({{(MB_W-FACT_W){1'b0}}, amp_q});
			end
			S_GAIN: begin
				mul_a = prod_q[MA_W+13:14];
				mul_b = signed'({{(MB_W-FACT_W){1'b0}}, gain_q});
			end
			S_LEFT: begin
				mul_a = prod_q[MA_W+13:14];
				mul_b = signed'({{(MB_W-SAMP_W){1'b0}}, wl});
			end
			S_RIGHT: begin
				mul_a = acc_q;
				mul_b = signed'({{(MB_W-SAMP_W-1){1'b0}}, wr});
			end
			S_INC_LO: begin
				mul_a = signed'({{(MA_W-HZ_W){1'b0}}, hz_to_phase_q});
				mul_b = signed'({{(MB_W-17){1'b0}}, fc_q[16:0]});
			end
			S_INC_HI: begin
				mul_a = signed'({{(MA_W-HZ_W){1'b0}}, hz_to_phase_q});
				mul_b = signed'({{(MB_W-(FREQ_W-17)){1'b0}}, fc_q[FREQ_W-1:17]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	// Round to nearest at bit 32 before saturation.
	assign rounded = prod_q + signed'(MP_W'(64'h8000_0000));
	// Phase increment from the two partial products, frequency split at bit 17.
	assign inc_sum = (MP_W+17)'(lo_q) + {prod_q, 17'b0};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= ENABLE_RST;
			wave_select_q <= WAVE_SELECT_RST;
			hz_to_phase_q <= HZ_TO_PHASE_RST;
			freq_limit_q  <= FREQ_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_ENABLE:      enable_q      <= cfg_wdata[0];
				REG_WAVE_SELECT: wave_select_q <= cfg_wdata[SEL_W-1:0];
				REG_HZ_TO_PHASE: hz_to_phase_q <= cfg_wdata[HZ_W-1:0];
				REG_FREQ_LIMIT:  freq_limit_q  <= cfg_wdata[FREQ_W-1:0];
			endcase
		end
	end

	// Sequencer, phase accumulator and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
		end else begin
			// In S_RSAT the output register is either reloaded or left holding its word.
			if (out_valid_q && out_ready && state_q != S_RSAT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && cmd == CMD_SAMPLE)
						state_q <= enable_q ? S_IDX_MUL : S_INC_LO;
				end
				S_IDX_MUL: state_q <= S_RDA;
				S_RDA:     state_q <= S_RDB;
				S_RDB:     state_q <= S_DIFF;
				S_DIFF:    state_q <= S_V;
				S_V:       state_q <= S_AMP;
				S_AMP:     state_q <= S_GAIN;
				S_GAIN:    state_q <= S_LEFT;
				S_LEFT:    state_q <= S_RIGHT;
				S_RIGHT:   state_q <= S_RSAT;
				S_RSAT: begin
					// Hold here while the previous word still waits to be taken.
					if (out_free) begin
						out_valid_q <= 1'b1;
						left_q      <= lpend_q;
						right_q     <= sat16(rounded[MP_W-1:32]);
						state_q     <= S_INC_LO;
					end
				end
				S_INC_LO:  state_q <= S_INC_HI;
				S_INC_HI:  state_q <= S_ADV;
				S_ADV: begin
					phase_q <= phase_q + inc_sum[PHASE_W+23:24];
					state_q <= S_IDLE;
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; they need no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_q    <= phase_q + phase_offset;
			fc_q   <= (freq_word < freq_limit_q) ? freq_word : freq_limit_q;
			amp_q  <= amplitude;
			gain_q <= gain;
			pan_q  <= pan;
		end
		unique case (state_q)
			S_IDX_MUL, S_DIFF, S_AMP, S_GAIN, S_INC_LO: prod_q <= prod;
			S_RDA: begin
				idx_q <= idx_c;
				f_q   <= prod_q[31:16];
			end
			S_RDB: a_q <= rd_q;
			S_V:   acc_q <= MA_W'(signed'({a_q, 16'b0})) + MA_W'(prod_q);
			S_LEFT: begin
				acc_q  <= mul_a;
				prod_q <= prod;
			end
			S_RIGHT: begin
				lpend_q <= sat16(rounded[MP_W-1:32]);
				prod_q  <= prod;
			end
			S_INC_HI: begin
				lo_q   <= prod_q;
				prod_q <= prod;
			end
			default: begin
			end
		endcase
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= table_data;
		rd_q <= mem[rd_addr];
	end

	// A table write never leaves the sequencer busy.
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == CMD_WRITE |=> state_q == S_IDLE)
		else $error("table write left the sequencer busy");

	// A disabled sample goes straight to the phase update.
	a_disabled_skips: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == CMD_SAMPLE && !enable_q |=> state_q == S_INC_LO)
		else $error("disabled sample entered the signal path");

	// A finished result is loaded whenever the output register is free.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RSAT && out_free |=> out_valid_q && state_q == S_INC_LO)
		else $error("result not loaded into a free output register");

	// A blocked result keeps its product until it can be delivered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RSAT && !out_free |=> state_q == S_RSAT && $stable(prod_q)
		&& $stable(lpend_q))
		else $error("pending result lost while the receiver stalls");

	// The phase update always returns the block to accepting words.
	a_adv_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADV |=> in_ready)
		else $error("sequencer did not return to idle after the phase update");

endmodule
